// ===== rtl/hpid_pkg.sv =====
// Shared widths, fixed-point constants, register indexes and datapath types
// for the heading PID controller. No dependencies.
package hpid_pkg;

  // Field and register widths
  localparam int ANG_W      = 15;  // Q3.12 angle
  localparam int MAG_W      = ANG_W - 1;
  localparam int MS_W       = 16;
  localparam int GAIN_W     = 24;  // Q8.16 gain
  localparam int LIM_W      = 15;
  localparam int TOL_W      = 13;
  localparam int CMD_W      = 16;
  localparam int ST_W       = 16;  // integrator state
  localparam int INT_W      = 22;  // integrator sum before the clamp

  // Serial units
  localparam int MUL_A_W    = GAIN_W;
  localparam int MUL_B_W    = 25;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W  = $clog2(MUL_B_W);
  localparam int DIV_N_W    = 30;
  localparam int DIV_D_W    = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_N_W);
  localparam int ACC_W      = 51;
  localparam int RND_SHIFT  = 16;  // Q8.16 gain times Q4.12 value back to Q4.12

  // Ports
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 32;

  localparam int MS_PER_S   = 1000;

  typedef logic signed [ANG_W-1:0]   angle_t;
  typedef logic signed [ANG_W:0]     diff_t;
  typedef logic signed [ANG_W+1:0]   dd_t;
  typedef logic        [MAG_W-1:0]   mag_t;
  typedef logic        [ANG_W:0]     ddmag_t;
  typedef logic        [MS_W-1:0]    ms_t;
  typedef logic        [GAIN_W-1:0]  gain_t;
  typedef logic        [LIM_W-1:0]   lim_t;
  typedef logic        [TOL_W-1:0]   tol_t;
  typedef logic signed [CMD_W-1:0]   cmd_t;
  typedef logic signed [ST_W-1:0]    st_t;
  typedef logic        [ST_W-1:0]    stmag_t;
  typedef logic signed [INT_W-1:0]   integ_t;
  typedef logic        [MUL_A_W-1:0] mul_a_t;
  typedef logic        [MUL_B_W-1:0] mul_b_t;
  typedef logic        [PROD_W-1:0]  prod_t;
  typedef logic        [MUL_CNT_W-1:0] mul_cnt_t;
  typedef logic        [DIV_N_W-1:0] div_num_t;
  typedef logic        [DIV_D_W-1:0] div_den_t;
  typedef logic        [DIV_CNT_W-1:0] div_cnt_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic        [ACC_W-1:0]   accmag_t;

  localparam diff_t Q_PI     = diff_t'(12868);
  localparam diff_t Q_TWO_PI = diff_t'(25736);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_RATE_LIMIT = 3'd3,
    REG_ANGLE_TOL  = 3'd4,
    REG_INT_LIMIT  = 3'd5
  } cfg_reg_e;

endpackage

// ===== rtl/hpid_mul.sv =====
// Radix-2 shift-add multiplier, one multiplier bit per cycle, unsigned.
// Depends on hpid_pkg for operand and product widths.
module hpid_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  hpid_pkg::mul_a_t    a_i,
  input  hpid_pkg::mul_b_t    b_i,
  output logic                done_o,
  output hpid_pkg::prod_t     prod_o
);

  hpid_pkg::mul_a_t   a_q;
  hpid_pkg::mul_a_t   hi_q;
  hpid_pkg::mul_b_t   lo_q;
  hpid_pkg::mul_cnt_t cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [hpid_pkg::MUL_A_W:0] sum;

  always_comb begin
    sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_q    <= a_i;
        hi_q   <= '0;
        lo_q   <= b_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // shift the partial product right; multiplier bits leave at the bottom
        hi_q <= sum[hpid_pkg::MUL_A_W:1];
        lo_q <= {sum[0], lo_q[hpid_pkg::MUL_B_W-1:1]};
        if (cnt_q == hpid_pkg::mul_cnt_t'(hpid_pkg::MUL_B_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

// ===== rtl/hpid_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned, nonzero divisor.
// Depends on hpid_pkg for dividend and divisor widths.
module hpid_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  hpid_pkg::div_num_t  num_i,
  input  hpid_pkg::div_den_t  den_i,
  output logic                done_o,
  output hpid_pkg::div_num_t  quo_o
);

  hpid_pkg::div_num_t quo_q;
  hpid_pkg::div_den_t den_q;
  hpid_pkg::div_den_t rem_q;
  hpid_pkg::div_cnt_t cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [hpid_pkg::DIV_D_W:0] trial;
  logic [hpid_pkg::DIV_D_W:0] trial_sub;
  logic                       fits;

  always_comb begin
    trial     = {rem_q, quo_q[hpid_pkg::DIV_N_W-1]};
    trial_sub = trial - {1'b0, den_q};
    fits      = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? trial_sub[hpid_pkg::DIV_D_W-1:0] : trial[hpid_pkg::DIV_D_W-1:0];
        quo_q <= {quo_q[hpid_pkg::DIV_N_W-2:0], fits};
        if (cnt_q == hpid_pkg::div_cnt_t'(hpid_pkg::DIV_N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/heading_pid_controller.sv =====
// Heading PID controller with anti-windup, Q3.12 angles and Q8.16 gains.
// Depends on hpid_pkg, hpid_mul (serial multiplier) and hpid_div (serial divider).
//
//   channel   direction  payload
//   s_axis    in         tdata: target_angle, measured_angle, elapsed_ms; tuser: new_target
//   m_axis    out        tdata: rate_command, angle_error; tuser: reached
//   cfg       in         cfg_we_i / cfg_idx_i / cfg_data_i, write only
//
// A tick with nonzero elapsed time, from acceptance until the input is ready again, runs
// four products on the shared shift-add multiplier and two quotients on the restoring
// divider, plus the control states ST_INTEG, ST_MAG, ST_CLAMP and ST_OUT.
// A tick with zero elapsed time is taken in ST_IDLE and gives no result.
// A finished result waits in the output register; the next tick is accepted and
// worked on meanwhile, and only the final load stalls on m_axis_tready.
// Reset clears integrator, previous error and output valid flag, and sets config defaults.
module heading_pid_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [14:0] target_angle, [29:15] measured_angle, [45:30] elapsed_ms, [47:46] zero
  input  logic [hpid_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] new_target
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] rate_command, [30:16] angle_error, [31] zero
  output logic [hpid_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] reached
  output logic                             m_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic [hpid_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hpid_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IMUL,
    ST_IDIV,
    ST_INTEG,
    ST_DDIV,
    ST_PMUL,
    ST_IMAC,
    ST_DMAC,
    ST_MAG,
    ST_CLAMP,
    ST_OUT
  } state_e;

  state_e state_q;

  // Configuration
  hpid_pkg::gain_t gain_p_q, gain_i_q, gain_d_q;
  hpid_pkg::lim_t  rate_limit_q, int_limit_q;
  hpid_pkg::tol_t  tol_q;

  // Controller state and working registers
  hpid_pkg::st_t     integ_q;
  hpid_pkg::angle_t  prev_q;
  hpid_pkg::angle_t  err_q;
  hpid_pkg::ms_t     ms_q;
  hpid_pkg::div_num_t dmag_q;
  logic              dneg_q;
  hpid_pkg::acc_t    acc_q;
  hpid_pkg::accmag_t accmag_q;
  logic              accneg_q;
  hpid_pkg::cmd_t    cmd_q;
  logic              reached_q;

  // Serial unit operands
  logic               mul_start_q;
  hpid_pkg::mul_a_t   mul_a_q;
  hpid_pkg::mul_b_t   mul_b_q;
  logic               mneg_q;
  logic               mul_done;
  hpid_pkg::prod_t    mul_prod;
  logic               div_start_q;
  hpid_pkg::div_num_t div_num_q;
  hpid_pkg::div_den_t div_den_q;
  logic               div_done;
  hpid_pkg::div_num_t div_quo;

  // Output register
  logic              out_valid_q;
  hpid_pkg::cmd_t    out_cmd_q;
  hpid_pkg::angle_t  out_err_q;
  logic              out_reached_q;

  // Combinational helpers
  hpid_pkg::angle_t   in_target, in_measured, in_err;
  hpid_pkg::ms_t      in_ms;
  hpid_pkg::diff_t    diff, wrapped;
  hpid_pkg::mag_t     in_errmag, err_mag;
  hpid_pkg::integ_t   term_mag, term, isum, ilim, iclamp;
  hpid_pkg::stmag_t   integ_mag;
  hpid_pkg::dd_t      dd;
  hpid_pkg::ddmag_t   dd_mag;
  hpid_pkg::div_num_t dd_ext, dnum;
  hpid_pkg::acc_t     prod_acc, acc_next;
  hpid_pkg::accmag_t  rnd, qmag;
  hpid_pkg::lim_t     cmd_mag;
  hpid_pkg::cmd_t     cmd_next;
  logic               reached_next;
  logic               in_take;
  logic               out_free;

  always_comb begin
    in_target   = s_axis_tdata[hpid_pkg::ANG_W-1:0];
    in_measured = s_axis_tdata[2*hpid_pkg::ANG_W-1:hpid_pkg::ANG_W];
    in_ms       = s_axis_tdata[2*hpid_pkg::ANG_W+hpid_pkg::MS_W-1:2*hpid_pkg::ANG_W];

    // wrap into [-pi, pi]; one correction covers the whole input range
    diff = hpid_pkg::diff_t'(in_target) - hpid_pkg::diff_t'(in_measured);
    if (diff > hpid_pkg::Q_PI) begin
      wrapped = diff - hpid_pkg::Q_TWO_PI;
    end else if (diff < -hpid_pkg::Q_PI) begin
      wrapped = diff + hpid_pkg::Q_TWO_PI;
    end else begin
      wrapped = diff;
    end
    in_err    = hpid_pkg::angle_t'(wrapped);
    in_errmag = in_err[hpid_pkg::ANG_W-1] ? hpid_pkg::mag_t'(-in_err)
                                          : hpid_pkg::mag_t'(in_err);
    err_mag   = err_q[hpid_pkg::ANG_W-1] ? hpid_pkg::mag_t'(-err_q)
                                         : hpid_pkg::mag_t'(err_q);

    // integrator update and clamp
    term_mag = hpid_pkg::integ_t'({1'b0, div_quo[hpid_pkg::INT_W-2:0]});
    term     = err_q[hpid_pkg::ANG_W-1] ? -term_mag : term_mag;
    isum     = hpid_pkg::integ_t'(integ_q) + term;
    ilim     = hpid_pkg::integ_t'({1'b0, int_limit_q});
    if (isum > ilim) begin
      iclamp = ilim;
    end else if (isum < -ilim) begin
      iclamp = -ilim;
    end else begin
      iclamp = isum;
    end
    integ_mag = integ_q[hpid_pkg::ST_W-1] ? hpid_pkg::stmag_t'(-integ_q)
                                          : hpid_pkg::stmag_t'(integ_q);

    // derivative numerator: |change| * 1000 as 1024 - 16 - 8, plus half the divisor
    dd     = hpid_pkg::dd_t'(err_q) - hpid_pkg::dd_t'(prev_q);
    dd_mag = dd[hpid_pkg::ANG_W+1] ? hpid_pkg::ddmag_t'(-dd) : hpid_pkg::ddmag_t'(dd);
    dd_ext = hpid_pkg::div_num_t'(dd_mag);
    dnum   = (dd_ext << 10) - (dd_ext << 4) - (dd_ext << 3)
           + hpid_pkg::div_num_t'(ms_q >> 1);

    prod_acc = hpid_pkg::acc_t'(mul_prod);
    acc_next = mneg_q ? acc_q - prod_acc : acc_q + prod_acc;

    // round half away from zero on the magnitude, then clamp
    rnd  = accmag_q + hpid_pkg::accmag_t'(1 << (hpid_pkg::RND_SHIFT - 1));
    qmag = rnd >> hpid_pkg::RND_SHIFT;
    if (qmag > hpid_pkg::accmag_t'(rate_limit_q)) begin
      cmd_mag = rate_limit_q;
    end else begin
      cmd_mag = hpid_pkg::lim_t'(qmag);
    end
    reached_next = err_mag < hpid_pkg::mag_t'(tol_q);
    if (reached_next) begin
      cmd_next = '0;
    end else if (accneg_q) begin
      cmd_next = -hpid_pkg::cmd_t'(cmd_mag);
    end else begin
      cmd_next = hpid_pkg::cmd_t'(cmd_mag);
    end

    in_take  = s_axis_tvalid && (state_q == ST_IDLE);
    out_free = !out_valid_q || m_axis_tready;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= hpid_pkg::gain_t'(196608);
      gain_i_q     <= hpid_pkg::gain_t'(7);
      gain_d_q     <= hpid_pkg::gain_t'(131072);
      rate_limit_q <= hpid_pkg::lim_t'(2048);
      tol_q        <= hpid_pkg::tol_t'(41);
      int_limit_q  <= hpid_pkg::lim_t'(4096);
    end else if (cfg_we_i) begin
      case (hpid_pkg::cfg_reg_e'(cfg_idx_i))
        hpid_pkg::REG_GAIN_P:     gain_p_q     <= cfg_data_i;
        hpid_pkg::REG_GAIN_I:     gain_i_q     <= cfg_data_i;
        hpid_pkg::REG_GAIN_D:     gain_d_q     <= cfg_data_i;
        hpid_pkg::REG_RATE_LIMIT: rate_limit_q <= cfg_data_i[hpid_pkg::LIM_W-1:0];
        hpid_pkg::REG_ANGLE_TOL:  tol_q        <= cfg_data_i[hpid_pkg::TOL_W-1:0];
        hpid_pkg::REG_INT_LIMIT:  int_limit_q  <= cfg_data_i[hpid_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, controller state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      integ_q     <= '0;
      prev_q      <= '0;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            err_q <= in_err;
            ms_q  <= in_ms;
            if (s_axis_tuser) begin
              integ_q <= '0;
              prev_q  <= '0;
            end
            if (in_ms != '0) begin
              mul_a_q     <= hpid_pkg::mul_a_t'(in_ms);
              mul_b_q     <= hpid_pkg::mul_b_t'(in_errmag);
              mul_start_q <= 1'b1;
              state_q     <= ST_IMUL;
            end
          end
        end
        ST_IMUL: begin
          if (mul_done) begin
            div_num_q   <= mul_prod[hpid_pkg::DIV_N_W-1:0]
                         + hpid_pkg::div_num_t'(hpid_pkg::MS_PER_S / 2);
            div_den_q   <= hpid_pkg::div_den_t'(hpid_pkg::MS_PER_S);
            div_start_q <= 1'b1;
            state_q     <= ST_IDIV;
          end
        end
        ST_IDIV: begin
          if (div_done) begin
            state_q <= ST_INTEG;
          end
        end
        ST_INTEG: begin
          integ_q     <= hpid_pkg::st_t'(iclamp);
          prev_q      <= err_q;
          dneg_q      <= dd[hpid_pkg::ANG_W+1];
          div_num_q   <= dnum;
          div_den_q   <= ms_q;
          div_start_q <= 1'b1;
          state_q     <= ST_DDIV;
        end
        ST_DDIV: begin
          if (div_done) begin
            dmag_q      <= div_quo;
            acc_q       <= '0;
            mul_a_q     <= gain_p_q;
            mul_b_q     <= hpid_pkg::mul_b_t'(err_mag);
            mneg_q      <= err_q[hpid_pkg::ANG_W-1];
            mul_start_q <= 1'b1;
            state_q     <= ST_PMUL;
          end
        end
        ST_PMUL: begin
          if (mul_done) begin
            acc_q       <= acc_next;
            mul_a_q     <= gain_i_q;
            mul_b_q     <= hpid_pkg::mul_b_t'(integ_mag);
            mneg_q      <= integ_q[hpid_pkg::ST_W-1];
            mul_start_q <= 1'b1;
            state_q     <= ST_IMAC;
          end
        end
        ST_IMAC: begin
          if (mul_done) begin
            acc_q       <= acc_next;
            mul_a_q     <= gain_d_q;
            mul_b_q     <= dmag_q[hpid_pkg::MUL_B_W-1:0];
            mneg_q      <= dneg_q;
            mul_start_q <= 1'b1;
            state_q     <= ST_DMAC;
          end
        end
        ST_DMAC: begin
          if (mul_done) begin
            acc_q   <= acc_next;
            state_q <= ST_MAG;
          end
        end
        ST_MAG: begin
          accneg_q <= acc_q[hpid_pkg::ACC_W-1];
          accmag_q <= acc_q[hpid_pkg::ACC_W-1] ? hpid_pkg::accmag_t'(-acc_q)
                                               : hpid_pkg::accmag_t'(acc_q);
          state_q  <= ST_CLAMP;
        end
        ST_CLAMP: begin
          cmd_q     <= cmd_next;
          reached_q <= reached_next;
          state_q   <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the output register drains
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_cmd_q     <= cmd_q;
            out_err_q     <= err_q;
            out_reached_q <= reached_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  hpid_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  hpid_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(hpid_pkg::M_TDATA_W - hpid_pkg::CMD_W - hpid_pkg::ANG_W){1'b0}},
                          out_err_q, out_cmd_q};
  assign m_axis_tuser  = out_reached_q;

endmodule

// ===== tb/tb_heading_pid_controller.sv =====
`timescale 1ns / 1ps
// Self-checking bench for heading_pid_controller: drives control ticks on s_axis,
// predicts each heading command and compares it with m_axis. Depends on hpid_pkg.
module tb_heading_pid_controller;

  localparam int      WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
  localparam int      SETTLE_CYCLES  = 200;
  localparam int      TICKS_PER_SET  = 81;
  localparam longint  GAIN_SCALE     = 65536; // Q8.16 one

  typedef enum int {
    SET_ZERO, SET_MAX, SET_WIDE, SET_TYPICAL, SET_RESET_VALUES, SET_LOOSE_TOL
  } setting_e;

  typedef struct {
    hpid_pkg::angle_t target_angle;
    hpid_pkg::angle_t measured_angle;
    hpid_pkg::ms_t    elapsed_ms;
    logic             new_target;
  } heading_tick_t;

  typedef struct {
    hpid_pkg::cmd_t   rate_command;
    hpid_pkg::angle_t angle_error;
    logic             reached;
  } heading_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [hpid_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tuser = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [hpid_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic                            m_axis_tuser;
  logic                            cfg_we_i = 1'b0;
  logic [hpid_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [hpid_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  heading_pid_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Controller model: register copies and integrator state
  hpid_pkg::gain_t gain_p_q = 24'd196608;
  hpid_pkg::gain_t gain_i_q = 24'd7;
  hpid_pkg::gain_t gain_d_q = 24'd131072;
  hpid_pkg::lim_t  rate_limit_q = 15'd2048;
  hpid_pkg::tol_t  tolerance_q = 13'd41;
  hpid_pkg::lim_t  integ_limit_q = 15'd4096;
  longint integ_state = 0;
  longint prev_error = 0;

  heading_tick_t   tick_queue[$];
  heading_result_t pending_results[$];
  heading_tick_t   drv_tick;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int ticks_queued = 0;
  int ticks_accepted = 0;
  int ticks_skipped = 0;
  int results_checked = 0;
  int reached_count = 0;
  int clamped_count = 0;
  int settings_run = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Work out the command for one accepted tick and queue it, unless its elapsed time is zero
  function automatic void predict_heading(heading_tick_t t);
    longint err, ms, integ, deriv, acc, cmd, rlim;
    heading_result_t res;
    if (t.new_target) begin
      integ_state = 0;
      prev_error = 0;
    end
    if (t.elapsed_ms == '0) begin
      ticks_skipped++;
      return;
    end
    ms = t.elapsed_ms;
    rlim = rate_limit_q;
    err = longint'(t.target_angle) - longint'(t.measured_angle);
    while (err > hpid_pkg::Q_PI) err -= hpid_pkg::Q_TWO_PI;
    while (err < -hpid_pkg::Q_PI) err += hpid_pkg::Q_TWO_PI;
    integ = clamp_sym(integ_state + round_div(err * ms, hpid_pkg::MS_PER_S), integ_limit_q);
    deriv = round_div((err - prev_error) * hpid_pkg::MS_PER_S, ms);
    acc = longint'(gain_p_q) * err + longint'(gain_i_q) * integ
        + longint'(gain_d_q) * deriv;
    cmd = round_div(acc, GAIN_SCALE);
    if (cmd > rlim || cmd < -rlim) clamped_count++;
    cmd = clamp_sym(cmd, rlim);
    res.reached = ((err < 0) ? -err : err) < longint'(tolerance_q);
    if (res.reached) begin
      cmd = 0;
      reached_count++;
    end
    res.rate_command = hpid_pkg::cmd_t'(cmd);
    res.angle_error = hpid_pkg::angle_t'(err);
    integ_state = integ;
    prev_error = err;
    pending_results.insert(pending_results.size(), res);
  endfunction

  function automatic void queue_tick(int target, int measured, int ms, bit nt);
    heading_tick_t t;
    t.target_angle = hpid_pkg::angle_t'(target);
    t.measured_angle = hpid_pkg::angle_t'(measured);
    t.elapsed_ms = hpid_pkg::ms_t'(ms);
    t.new_target = nt;
    tick_queue.insert(tick_queue.size(), t);
    ticks_queued++;
  endfunction

  function automatic hpid_pkg::ms_t pick_elapsed();
    int r;
    r = $urandom_range(99);
    if (r < 65) return hpid_pkg::ms_t'($urandom_range(120, 80));
    if (r < 77) return hpid_pkg::ms_t'($urandom_range(9, 1));
    if (r < 87) return '0;
    return hpid_pkg::ms_t'($urandom);
  endfunction

  // Mostly approach sequences that settle on a target, plus raw noise ticks
  task automatic queue_random_ticks(int count);
    int made, seq_len, tgt, offset, meas;
    hpid_pkg::ms_t ms;
    bit nt;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 75) begin
        seq_len = $urandom_range(10, 3);
        tgt = int'($urandom_range(25736)) - 12868;
        offset = int'($urandom_range(24000)) - 12000;
        for (int k = 0; k < seq_len; k++) begin
          meas = tgt - offset + int'($urandom_range(40)) - 20;
          if (meas > 16383) meas = 16383;
          if (meas < -16384) meas = -16384;
          ms = pick_elapsed();
          nt = (k == 0) || ($urandom_range(99) < 3);
          queue_tick(tgt, meas, ms, nt);
          if (ms != '0 || nt) made++;
          offset = offset * int'($urandom_range(80, 30)) / 100;
        end
      end else begin
        ms = pick_elapsed();
        nt = $urandom_range(1);
        queue_tick($urandom, $urandom, ms, nt);
        if (ms != '0 || nt) made++;
      end
    end
  endtask

  task automatic write_reg(hpid_pkg::cfg_reg_e idx, logic [hpid_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      hpid_pkg::REG_GAIN_P:     gain_p_q = val;
      hpid_pkg::REG_GAIN_I:     gain_i_q = val;
      hpid_pkg::REG_GAIN_D:     gain_d_q = val;
      hpid_pkg::REG_RATE_LIMIT: rate_limit_q = val[hpid_pkg::LIM_W-1:0];
      hpid_pkg::REG_ANGLE_TOL:  tolerance_q = val[hpid_pkg::TOL_W-1:0];
      hpid_pkg::REG_INT_LIMIT:  integ_limit_q = val[hpid_pkg::LIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(setting_e kind);
    logic [hpid_pkg::CFG_DATA_W-1:0] vals[6];
    vals[hpid_pkg::REG_GAIN_P] = $urandom_range(10 * 65536);
    vals[hpid_pkg::REG_GAIN_I] = $urandom_range(4096);
    vals[hpid_pkg::REG_GAIN_D] = $urandom_range(4 * 65536);
    vals[hpid_pkg::REG_RATE_LIMIT] = $urandom_range(16384, 256);
    vals[hpid_pkg::REG_ANGLE_TOL] = $urandom_range(400);
    vals[hpid_pkg::REG_INT_LIMIT] = $urandom_range(16384);
    case (kind)
      SET_ZERO: begin
        foreach (vals[i]) vals[i] = '0;
      end
      SET_MAX: begin
        vals[hpid_pkg::REG_GAIN_P] = '1;
        vals[hpid_pkg::REG_GAIN_I] = '1;
        vals[hpid_pkg::REG_GAIN_D] = '1;
        vals[hpid_pkg::REG_RATE_LIMIT] = 24'h7FFF;
        vals[hpid_pkg::REG_ANGLE_TOL] = '0;
        vals[hpid_pkg::REG_INT_LIMIT] = 24'h7FFF;
      end
      SET_WIDE: begin
        vals[hpid_pkg::REG_GAIN_P] = $urandom;
        vals[hpid_pkg::REG_GAIN_I] = $urandom;
        vals[hpid_pkg::REG_GAIN_D] = $urandom;
        vals[hpid_pkg::REG_RATE_LIMIT] = 24'd16384;
        vals[hpid_pkg::REG_ANGLE_TOL] = 24'd4096;
        vals[hpid_pkg::REG_INT_LIMIT] = 24'd16384;
      end
      SET_RESET_VALUES: begin
        vals[hpid_pkg::REG_GAIN_P] = 24'd196608;
        vals[hpid_pkg::REG_GAIN_I] = 24'd7;
        vals[hpid_pkg::REG_GAIN_D] = 24'd131072;
        vals[hpid_pkg::REG_RATE_LIMIT] = 24'd2048;
        vals[hpid_pkg::REG_ANGLE_TOL] = 24'd41;
        vals[hpid_pkg::REG_INT_LIMIT] = 24'd4096;
      end
      SET_LOOSE_TOL: begin
        vals[hpid_pkg::REG_ANGLE_TOL] = 24'h1FFF;
        vals[hpid_pkg::REG_INT_LIMIT] = '0;
      end
      default: ;
    endcase
    for (int i = 0; i < 6; i++) write_reg(hpid_pkg::cfg_reg_e'(i), vals[i]);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  // Hold until every tick is taken and every result is back, then let the block settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (ticks_accepted != ticks_queued || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_heading(drv_tick);
        ticks_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_tick = tick_queue.pop_front();
          s_axis_tdata <= {2'b00, drv_tick.elapsed_ms, drv_tick.measured_angle,
                           drv_tick.target_angle};
          s_axis_tuser <= drv_tick.new_target;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    heading_result_t  want;
    hpid_pkg::cmd_t   got_cmd;
    hpid_pkg::angle_t got_err;
    logic             got_reached;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_cmd = m_axis_tdata[15:0];
        got_err = m_axis_tdata[30:16];
        got_reached = m_axis_tuser;
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, command %0d error %0d reached %0b",
                   $time, got_cmd, got_err, got_reached);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (got_cmd !== want.rate_command) begin
            mismatch_count++;
            $display("%0t: rate_command expected %0d actual %0d",
                     $time, want.rate_command, got_cmd);
          end
          if (got_err !== want.angle_error) begin
            mismatch_count++;
            $display("%0t: angle_error expected %0d actual %0d",
                     $time, want.angle_error, got_err);
          end
          if (got_reached !== want.reached) begin
            mismatch_count++;
            $display("%0t: reached expected %0b actual %0b",
                     $time, want.reached, got_reached);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    setting_e phase_kind[8];
    int       send_pct[4];
    int       stall_pct[4];
    phase_kind = '{SET_TYPICAL, SET_ZERO, SET_MAX, SET_TYPICAL,
                   SET_WIDE, SET_LOOSE_TOL, SET_TYPICAL, SET_RESET_VALUES};
    send_pct = '{0, 52, 0, 34};
    stall_pct = '{0, 0, 52, 34};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset register values: wrap limits, raw field extremes, tolerance edges, skips
    queue_tick(0, 0, 100, 1);
    queue_tick(12868, -12868, 100, 0);
    queue_tick(-12868, 12868, 100, 0);
    queue_tick(16383, -16384, 100, 0);
    queue_tick(-16384, 16383, 100, 0);
    queue_tick(12868, 0, 1, 0);
    queue_tick(-12868, 0, 65535, 0);
    queue_tick(40, 0, 100, 1);
    queue_tick(41, 0, 100, 0);
    queue_tick(-41, 0, 100, 0);
    queue_tick(-40, 0, 100, 0);
    queue_tick(1000, 200, 0, 0);
    queue_tick(1000, 200, 1000, 0);
    queue_tick(1000, 200, 0, 1);
    queue_tick(1000, 200, 1000, 0);
    queue_tick(12868, 12868, 65535, 1);
    queue_tick(0, 12868, 100, 0);
    queue_tick(0, -12868, 100, 0);
    queue_tick(1, -12868, 100, 0);
    queue_tick(16383, -1, 32768, 0);
    queue_tick(-16384, -16384, 32768, 0);

    foreach (phase_kind[p]) begin
      wait_drained();
      apply_setting(phase_kind[p]);
      @(negedge clk_i);
      send_idle_pct = send_pct[(p + 1) % 4];
      recv_stall_pct = stall_pct[(p + 1) % 4];
      queue_random_ticks(TICKS_PER_SET);
    end
    wait_drained();

    $display("Sent %0d ticks (%0d with zero elapsed time) and checked %0d results,",
             ticks_accepted, ticks_skipped, results_checked);
    $display("%0d at target and %0d rate-limited, across %0d register settings",
             reached_count, clamped_count, settings_run + 1);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
